### sv/usc_pkg.sv
package usc_pkg;

    // Script classes that own a counter, in the order the winner search visits them.
    localparam int NUM_CLASSES = 5;
    localparam int CLS_CYR     = 0;
    localparam int CLS_LAT     = 1;
    localparam int CLS_ARA     = 2;
    localparam int CLS_CJK     = 3;
    localparam int CLS_DEV     = 4;

    // Width of a decoded code point.
    localparam int CP_W = 21;

    typedef logic [CP_W-1:0]        cp_t;
    typedef logic [NUM_CLASSES-1:0] class_vec_t;

    // Script codes that the block reports.
    typedef enum logic [2:0] {
        SCRIPT_LATIN      = 3'd0,
        SCRIPT_CYRILLIC   = 3'd1,
        SCRIPT_ARABIC     = 3'd2,
        SCRIPT_CJK        = 3'd3,
        SCRIPT_DEVANAGARI = 3'd4,
        SCRIPT_TURKMEN    = 3'd5
    } script_t;

    // Sequence lengths given by a lead byte.
    localparam logic [2:0] SEQ_LEN_1 = 3'd1;
    localparam logic [2:0] SEQ_LEN_2 = 3'd2;
    localparam logic [2:0] SEQ_LEN_3 = 3'd3;
    localparam logic [2:0] SEQ_LEN_4 = 3'd4;

    // Code point ranges of the counted scripts.
    localparam cp_t CYR_LO     = 21'h000400;
    localparam cp_t CYR_HI     = 21'h0004FF;
    localparam cp_t UPPER_LO   = 21'h000041;
    localparam cp_t UPPER_HI   = 21'h00005A;
    localparam cp_t LOWER_LO   = 21'h000061;
    localparam cp_t LOWER_HI   = 21'h00007A;
    localparam cp_t ARA_LO     = 21'h000600;
    localparam cp_t ARA_HI     = 21'h0006FF;
    localparam cp_t HAN_LO     = 21'h004E00;
    localparam cp_t HAN_HI     = 21'h009FFF;
    localparam cp_t KANA_LO    = 21'h003040;
    localparam cp_t KANA_HI    = 21'h0030FF;
    localparam cp_t HANGUL_LO  = 21'h00AC00;
    localparam cp_t HANGUL_HI  = 21'h00D7AF;
    localparam cp_t DEV_LO     = 21'h000900;
    localparam cp_t DEV_HI     = 21'h00097F;

    // Letters that mark Turkmen text.
    localparam cp_t TK_A_UML_LO  = 21'h0000E4;
    localparam cp_t TK_A_UML_UP  = 21'h0000C4;
    localparam cp_t TK_Z_CAR_LO  = 21'h00017E;
    localparam cp_t TK_Z_CAR_UP  = 21'h00017D;
    localparam cp_t TK_N_CAR_LO  = 21'h000148;
    localparam cp_t TK_N_CAR_UP  = 21'h000147;
    localparam cp_t TK_S_CED_LO  = 21'h00015F;
    localparam cp_t TK_S_CED_UP  = 21'h00015E;
    localparam cp_t TK_Y_ACU_LO  = 21'h0000FD;
    localparam cp_t TK_Y_ACU_UP  = 21'h0000DD;

    // One item passed from the decoder to the counters.
    typedef struct packed {
        logic [NUM_CLASSES-1:0][1:0] inc;
        logic                        turkmen;
        logic                        last;
    } usc_event_t;

    localparam int EVENT_W = $bits(usc_event_t);

    // Total length of the sequence opened by a lead byte; one if it is no multi-byte lead.
    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] len;
        begin
            len = SEQ_LEN_1;
            if (b[7:5] == 3'b110)
            begin
                len = SEQ_LEN_2;
            end
            else if (b[7:4] == 4'b1110)
            begin
                len = SEQ_LEN_3;
            end
            else if (b[7:3] == 5'b11110)
            begin
                len = SEQ_LEN_4;
            end
            return len;
        end
    endfunction

    // One-hot class of a code point, or all zero when it counts toward nothing.
    function automatic class_vec_t cp_class(input cp_t cp);
        class_vec_t cls;
        begin
            cls = '0;
            if (cp >= CYR_LO && cp <= CYR_HI)
            begin
                cls[CLS_CYR] = 1'b1;
            end
            else if ((cp >= UPPER_LO && cp <= UPPER_HI) || (cp >= LOWER_LO && cp <= LOWER_HI))
            begin
                cls[CLS_LAT] = 1'b1;
            end
            else if (cp >= ARA_LO && cp <= ARA_HI)
            begin
                cls[CLS_ARA] = 1'b1;
            end
            else if ((cp >= HAN_LO && cp <= HAN_HI) || (cp >= KANA_LO && cp <= KANA_HI) ||
                     (cp >= HANGUL_LO && cp <= HANGUL_HI))
            begin
                cls[CLS_CJK] = 1'b1;
            end
            else if (cp >= DEV_LO && cp <= DEV_HI)
            begin
                cls[CLS_DEV] = 1'b1;
            end
            return cls;
        end
    endfunction

    // True for any of the Turkmen marker letters.
    function automatic logic is_turkmen(input cp_t cp);
        begin
            return (cp == TK_A_UML_LO) || (cp == TK_A_UML_UP) ||
                   (cp == TK_Z_CAR_LO) || (cp == TK_Z_CAR_UP) ||
                   (cp == TK_N_CAR_LO) || (cp == TK_N_CAR_UP) ||
                   (cp == TK_S_CED_LO) || (cp == TK_S_CED_UP) ||
                   (cp == TK_Y_ACU_LO) || (cp == TK_Y_ACU_UP);
        end
    endfunction

endpackage

### sv/usc_fifo.sv
module usc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic [WIDTH-1:0]                 wr_data,
    output logic                             full,
    input  logic                             pop,
    output logic [WIDTH-1:0]                 rd_data,
    output logic                             empty,
    output logic [$clog2(DEPTH+1)-1:0]       count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    // Status flags and the head of the queue.
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointer and occupancy update with wrap at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // The surrounding logic never pushes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("usc_fifo: push while full");

    // The surrounding logic never pops an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("usc_fifo: pop while empty");

endmodule

### sv/usc_front.sv
module usc_front
    import usc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] text_byte,
    input  logic       is_last,
    output logic       evt_push,
    output usc_event_t evt
);

    logic [1:0]  bse_reg;
    logic [1:0]  bse_next;
    logic [1:0]  stored_reg;
    logic [1:0]  stored_next;
    cp_t         partial_reg;
    cp_t         partial_next;
    logic [7:0]  pend1_reg;
    logic [7:0]  pend1_next;
    logic [7:0]  pend2_reg;
    logic [7:0]  pend2_next;

    logic [2:0]  lead_len;
    cp_t         cpa;
    logic        cpa_v;
    cp_t         cpx;
    logic        cpx_v;
    cp_t         cpy;
    logic        cpy_v;
    class_vec_t  clsx;
    class_vec_t  clsy;

    assign lead_len = seq_len(text_byte);

    // Byte decode: start, extend or close a sequence, and replay a truncated tail.
    always_comb
    begin
        bse_next     = bse_reg;
        stored_next  = stored_reg;
        partial_next = partial_reg;
        pend1_next   = pend1_reg;
        pend2_next   = pend2_reg;
        cpa          = '0;
        cpa_v        = 1'b0;
        cpx          = '0;
        cpx_v        = 1'b0;
        cpy          = '0;
        cpy_v        = 1'b0;

        if (bse_reg == 2'd0)
        begin
            if (!text_byte[7])
            begin
                cpa   = CP_W'(text_byte);
                cpa_v = 1'b1;
            end
            else if (lead_len != SEQ_LEN_1)
            begin
                bse_next     = 2'(lead_len - 3'd1);
                stored_next  = 2'd1;
                partial_next = CP_W'(text_byte & (8'h7F >> lead_len));
            end
        end
        else
        begin
            partial_next = {partial_reg[CP_W-7:0], text_byte[5:0]};
            bse_next     = bse_reg - 2'd1;
            stored_next  = stored_reg + 2'd1;
            if (stored_reg == 2'd1)
            begin
                pend1_next = text_byte;
            end
            if (stored_reg == 2'd2)
            begin
                pend2_next = text_byte;
            end
            if (bse_next == 2'd0)
            begin
                cpa         = partial_next;
                cpa_v       = 1'b1;
                stored_next = 2'd0;
            end
        end

        cpx   = cpa;
        cpx_v = cpa_v;

        // A string that ends inside a sequence drops the lead and decodes what followed it.
        if (is_last && bse_next != 2'd0 && stored_next != 2'd1)
        begin
            cpx_v = 1'b0;
            if (stored_next == 2'd2)
            begin
                if (!pend1_next[7])
                begin
                    cpx   = CP_W'(pend1_next);
                    cpx_v = 1'b1;
                end
            end
            else
            begin
                if (!pend1_next[7])
                begin
                    cpx   = CP_W'(pend1_next);
                    cpx_v = 1'b1;
                    if (!pend2_next[7])
                    begin
                        cpy   = CP_W'(pend2_next);
                        cpy_v = 1'b1;
                    end
                end
                else if (seq_len(pend1_next) == SEQ_LEN_2)
                begin
                    cpx   = CP_W'({pend1_next[4:0], pend2_next[5:0]});
                    cpx_v = 1'b1;
                end
                else if (!pend2_next[7])
                begin
                    cpy   = CP_W'(pend2_next);
                    cpy_v = 1'b1;
                end
            end
        end

        // The string's end returns the decoder to its idle state.
        if (is_last)
        begin
            bse_next     = 2'd0;
            stored_next  = 2'd0;
            partial_next = '0;
        end
    end

    // Per-class increments for the up to two code points of this item.
    always_comb
    begin
        clsx = cpx_v ? cp_class(cpx) : '0;
        clsy = cpy_v ? cp_class(cpy) : '0;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            evt.inc[c] = {1'b0, clsx[c]} + {1'b0, clsy[c]};
        end
        evt.turkmen = (cpx_v && is_turkmen(cpx)) || (cpy_v && is_turkmen(cpy));
        evt.last    = is_last;
    end

    assign evt_push = in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bse_reg     <= 2'd0;
            stored_reg  <= 2'd0;
            partial_reg <= '0;
        end
        else if (in_valid)
        begin
            bse_reg     <= bse_next;
            stored_reg  <= stored_next;
            partial_reg <= partial_next;
        end
    end

    // Bytes held for a possible tail replay need no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            pend1_reg <= pend1_next;
            pend2_reg <= pend2_next;
        end
    end

    // A sequence is open exactly when its lead and maybe more bytes are stored.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (bse_reg == 2'd0) == (stored_reg == 2'd0))
        else $error("usc_front: open sequence and stored count disagree");

endmodule

### sv/usc_back.sv
module usc_back
    import usc_pkg::*;
#(
    parameter int COUNT_BITS = 16,
    parameter int RES_DEPTH  = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             evt_valid,
    input  usc_event_t                       evt,
    output logic                             evt_pop,
    input  logic [$clog2(RES_DEPTH+1)-1:0]   res_count,
    output logic                             res_push,
    output script_t                          res_code
);

    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] count_reg [NUM_CLASSES];
    logic [COUNT_BITS-1:0] count_sat [NUM_CLASSES];
    logic                  turk_reg;
    logic                  turk_new;

    // Snapshot of the final counts of one string.
    logic                  snap_v_reg;
    logic [COUNT_BITS-1:0] snap_count_reg [NUM_CLASSES];
    logic                  snap_turk_reg;

    // First compare stage: two pairwise winners.
    logic                  t1_v_reg;
    logic [COUNT_BITS-1:0] a_val_reg;
    script_t               a_code_reg;
    logic [COUNT_BITS-1:0] b_val_reg;
    script_t               b_code_reg;
    logic [COUNT_BITS-1:0] t1_dev_reg;
    logic                  t1_turk_reg;

    // Second compare stage: winner of the first four classes.
    logic                  t2_v_reg;
    logic [COUNT_BITS-1:0] w_val_reg;
    script_t               w_code_reg;
    logic [COUNT_BITS-1:0] t2_dev_reg;
    logic                  t2_turk_reg;

    logic [1:0]            in_flight;
    logic [RES_CNT_W:0]    committed;

    // Accept an item only while the result queue has room for every string in flight.
    always_comb
    begin
        in_flight = 2'(snap_v_reg) + 2'(t1_v_reg);
        in_flight = in_flight + 2'(t2_v_reg);
        committed = (RES_CNT_W + 1)'(res_count) + (RES_CNT_W + 1)'(in_flight);
        evt_pop   = evt_valid && (committed < (RES_CNT_W + 1)'(RES_DEPTH));
    end

    // Saturating counter update.
    always_comb
    begin
        logic [COUNT_BITS:0] sum;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            sum          = {1'b0, count_reg[c]} + (COUNT_BITS + 1)'(evt.inc[c]);
            count_sat[c] = sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
        end
        turk_new = turk_reg || evt.turkmen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                count_reg[c] <= '0;
            end
            turk_reg   <= 1'b0;
            snap_v_reg <= 1'b0;
            t1_v_reg   <= 1'b0;
            t2_v_reg   <= 1'b0;
        end
        else
        begin
            if (evt_pop)
            begin
                for (int c = 0; c < NUM_CLASSES; c++)
                begin
                    count_reg[c] <= evt.last ? '0 : count_sat[c];
                end
                turk_reg <= evt.last ? 1'b0 : turk_new;
            end
            snap_v_reg <= evt_pop && evt.last;
            t1_v_reg   <= snap_v_reg;
            t2_v_reg   <= t1_v_reg;
        end
    end

    // Winner search pipeline; a later class wins only when strictly greater.
    always_ff @(posedge clk)
    begin
        if (evt_pop && evt.last)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                snap_count_reg[c] <= count_sat[c];
            end
            snap_turk_reg <= turk_new;
        end

        if (snap_count_reg[CLS_LAT] > snap_count_reg[CLS_CYR])
        begin
            a_val_reg  <= snap_count_reg[CLS_LAT];
            a_code_reg <= SCRIPT_LATIN;
        end
        else
        begin
            a_val_reg  <= snap_count_reg[CLS_CYR];
            a_code_reg <= SCRIPT_CYRILLIC;
        end
        if (snap_count_reg[CLS_CJK] > snap_count_reg[CLS_ARA])
        begin
            b_val_reg  <= snap_count_reg[CLS_CJK];
            b_code_reg <= SCRIPT_CJK;
        end
        else
        begin
            b_val_reg  <= snap_count_reg[CLS_ARA];
            b_code_reg <= SCRIPT_ARABIC;
        end
        t1_dev_reg  <= snap_count_reg[CLS_DEV];
        t1_turk_reg <= snap_turk_reg;

        if (b_val_reg > a_val_reg)
        begin
            w_val_reg  <= b_val_reg;
            w_code_reg <= b_code_reg;
        end
        else
        begin
            w_val_reg  <= a_val_reg;
            w_code_reg <= a_code_reg;
        end
        t2_dev_reg  <= t1_dev_reg;
        t2_turk_reg <= t1_turk_reg;
    end

    // Final pick: Turkmen overrides, a string with no counted code point reads as Latin.
    always_comb
    begin
        if (t2_turk_reg)
        begin
            res_code = SCRIPT_TURKMEN;
        end
        else if (t2_dev_reg > w_val_reg)
        begin
            res_code = SCRIPT_DEVANAGARI;
        end
        else if (w_val_reg == '0)
        begin
            res_code = SCRIPT_LATIN;
        end
        else
        begin
            res_code = w_code_reg;
        end
    end

    assign res_push = t2_v_reg;

    // The end of a string leaves every counter and the Turkmen flag cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (evt_pop && evt.last) |=>
                     (count_reg[CLS_CYR] == '0 && count_reg[CLS_LAT] == '0 &&
                      count_reg[CLS_ARA] == '0 && count_reg[CLS_CJK] == '0 &&
                      count_reg[CLS_DEV] == '0 && !turk_reg))
        else $error("usc_back: state not cleared after end of string");

    // Every finished result finds a free slot in the result queue.
    assert property (@(posedge clk) disable iff (!rst_n)
                     res_push |-> (res_count < RES_CNT_W'(RES_DEPTH)))
        else $error("usc_back: result queue has no room for a finished result");

endmodule

### sv/utf8_script_classifier_core.sv
// UTF-8 script classifier. Bytes of a string enter one per cycle through a queue-style
// port (push/full), unless full holds them off, and are decoded leniently as UTF-8; each
// code point bumps a saturating counter for Cyrillic, ASCII Latin, Arabic, CJK/kana/Hangul
// or Devanagari, and any Turkmen marker letter forces the Turkmen code. The byte flagged
// is_last yields one script code on the result queue (empty/pop); no other byte yields a
// result. The sustained rate is one byte per cycle while the item queue has room, set by
// the decoder's sequence state, which updates once per byte. A decoder stage feeds an
// item queue, and the counter stage drains it while the result queue has room; a string's
// result passes through a count snapshot and two compare stages of the winner search.
module utf8_script_classifier_core
    import usc_pkg::*;
#(
    parameter int COUNT_BITS = 16,
    parameter int EVT_DEPTH  = 4,
    parameter int RES_DEPTH  = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] text_byte,
    input  logic       is_last,
    output logic       empty,
    input  logic       pop,
    output logic [2:0] script_code
);

    logic                               in_valid;
    logic                               evt_push;
    usc_event_t                         evt_in;
    usc_event_t                         evt_head;
    logic [EVENT_W-1:0]                 evt_rd_data;
    logic                               evt_empty;
    logic                               evt_pop;
    logic [$clog2(EVT_DEPTH+1)-1:0]     evt_count;
    logic [$clog2(RES_DEPTH+1)-1:0]     res_count;
    logic                               res_full;
    logic                               res_push;
    script_t                            res_code;
    logic                               res_pop;

    // An item is taken whenever it is pushed and the item queue has room.
    assign in_valid = push && !full;
    assign res_pop  = pop && !empty;
    assign evt_head = evt_rd_data;

    usc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .text_byte (text_byte),
        .is_last   (is_last),
        .evt_push  (evt_push),
        .evt       (evt_in)
    );

    usc_fifo #(
        .WIDTH (EVENT_W),
        .DEPTH (EVT_DEPTH)
    ) u_evt_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (evt_push),
        .wr_data (evt_in),
        .full    (full),
        .pop     (evt_pop),
        .rd_data (evt_rd_data),
        .empty   (evt_empty),
        .count   (evt_count)
    );

    usc_back #(
        .COUNT_BITS (COUNT_BITS),
        .RES_DEPTH  (RES_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (!evt_empty),
        .evt       (evt_head),
        .evt_pop   (evt_pop),
        .res_count (res_count),
        .res_push  (res_push),
        .res_code  (res_code)
    );

    usc_fifo #(
        .WIDTH (3),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_code),
        .full    (res_full),
        .pop     (res_pop),
        .rd_data (script_code),
        .empty   (empty),
        .count   (res_count)
    );

    // The item queue's fill level agrees with its flag, and a finished result never meets
    // a full result queue.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (evt_empty == (evt_count == '0)) && !(res_push && res_full))
        else $error("utf8_script_classifier_core: queue flags disagree");

endmodule

### bench/script_code_checker.sv
`timescale 1ns / 100ps

// Watches both queue ports of the script classifier, keeps its own model of the
// decoder and counters, and compares every popped script code with the oldest
// prediction.
module script_code_checker
    import usc_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       full,
    input  logic [7:0] text_byte,
    input  logic       is_last,
    input  logic       empty,
    input  logic       pop,
    input  logic [2:0] script_code,
    output int         mismatches,
    output int         outstanding,
    output int         bytes_seen,
    output int         strings_seen,
    output int         saturated_strings,
    output logic [5:0] codes_seen
);

    localparam logic [COUNT_BITS-1:0] TALLY_MAX = '1;

    // Model state: one counter per script class, the Turkmen flag and the open sequence.
    logic [COUNT_BITS-1:0] tally [NUM_CLASSES];
    logic                  turk_hit;
    logic                  hit_ceiling;
    int                    need;
    logic [20:0]           partial;
    logic [7:0]            lead_bytes [3];

    // Script codes predicted for strings whose last item was accepted.
    script_t expected_scripts [$];

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Number of bytes in the sequence that this byte opens, or 1 for no multi-byte lead.
    function automatic int span_of(input logic [7:0] b);
        if (b[7:5] == 3'b110)
            return 2;
        if (b[7:4] == 4'b1110)
            return 3;
        if (b[7:3] == 5'b11110)
            return 4;
        return 1;
    endfunction

    // Count one decoded code point; counters stick at their top value.
    function automatic void tally_cp(input logic [20:0] cp);
        int cls;
        cls = -1;
        if (cp >= 21'h400 && cp <= 21'h4FF)
            cls = CLS_CYR;
        else if ((cp >= 21'h41 && cp <= 21'h5A) || (cp >= 21'h61 && cp <= 21'h7A))
            cls = CLS_LAT;
        else if (cp >= 21'h600 && cp <= 21'h6FF)
            cls = CLS_ARA;
        else if ((cp >= 21'h4E00 && cp <= 21'h9FFF) || (cp >= 21'h3040 && cp <= 21'h30FF) ||
                 (cp >= 21'hAC00 && cp <= 21'hD7AF))
            cls = CLS_CJK;
        else if (cp >= 21'h900 && cp <= 21'h97F)
            cls = CLS_DEV;

        if (cls >= 0)
        begin
            if (tally[cls] == TALLY_MAX)
                hit_ceiling = 1'b1;
            else
                tally[cls] = tally[cls] + 1'b1;
        end

        case (cp)
            21'hC4, 21'hE4, 21'hDD, 21'hFD, 21'h147, 21'h148,
            21'h15E, 21'h15F, 21'h17D, 21'h17E: turk_hit = 1'b1;
            default: ;
        endcase
    endfunction

    // A string that ends inside a sequence: drop the lead and decode the stored
    // followers again as a string of their own.
    function automatic void retry_tail(input int n);
        int          i;
        int          span;
        int          k;
        logic [20:0] cp;
        logic [7:0]  c;
        i = 0;
        while (i < n)
        begin
            c = lead_bytes[1 + i];
            if (c < 8'h80)
            begin
                tally_cp({13'd0, c});
                i++;
            end
            else
            begin
                span = span_of(c);
                if (span > 1 && i + span - 1 < n)
                begin
                    cp = {13'd0, c & (8'h7F >> span)};
                    for (k = 1; k < span; k++)
                        cp = {cp[14:0], lead_bytes[1 + i + k][5:0]};
                    tally_cp(cp);
                    i += span;
                end
                else
                begin
                    tally_cp('0);
                    i++;
                end
            end
        end
    endfunction

    // Winner search: Turkmen overrides, otherwise a later class needs a strictly larger count.
    function automatic script_t pick_script();
        script_t               code;
        logic [COUNT_BITS-1:0] best;
        if (turk_hit)
            return SCRIPT_TURKMEN;
        code = SCRIPT_LATIN;
        best = '0;
        if (tally[CLS_CYR] > best)
        begin
            best = tally[CLS_CYR];
            code = SCRIPT_CYRILLIC;
        end
        if (tally[CLS_LAT] > best)
        begin
            best = tally[CLS_LAT];
            code = SCRIPT_LATIN;
        end
        if (tally[CLS_ARA] > best)
        begin
            best = tally[CLS_ARA];
            code = SCRIPT_ARABIC;
        end
        if (tally[CLS_CJK] > best)
        begin
            best = tally[CLS_CJK];
            code = SCRIPT_CJK;
        end
        if (tally[CLS_DEV] > best)
        begin
            best = tally[CLS_DEV];
            code = SCRIPT_DEVANAGARI;
        end
        return code;
    endfunction

    function automatic void clear_state();
        int i;
        for (i = 0; i < NUM_CLASSES; i++)
            tally[i] = '0;
        for (i = 0; i < 3; i++)
            lead_bytes[i] = '0;
        turk_hit    = 1'b0;
        hit_ceiling = 1'b0;
        need        = 0;
        partial     = '0;
    endfunction

    // Advance the model by one accepted item; the last byte of a string yields a prediction.
    function automatic void absorb_byte(input logic [7:0] b, input logic last);
        int span;
        int slot;
        int stored;
        if (need == 0)
        begin
            if (b < 8'h80)
            begin
                tally_cp({13'd0, b});
            end
            else
            begin
                span = span_of(b);
                if (span > 1)
                begin
                    need          = span - 1;
                    partial       = {13'd0, b & (8'h7F >> span)};
                    lead_bytes[0] = b;
                end
                else
                begin
                    tally_cp('0);
                end
            end
        end
        else
        begin
            span = span_of(lead_bytes[0]);
            slot = span - need;
            if (slot < 3)
                lead_bytes[slot] = b;
            partial = {partial[14:0], b[5:0]};
            need--;
            if (need == 0)
                tally_cp(partial);
        end

        if (last)
        begin
            if (need != 0)
            begin
                stored = span_of(lead_bytes[0]) - need;
                if (stored > 3)
                    stored = 3;
                if (stored > 1)
                    retry_tail(stored - 1);
            end
            expected_scripts.push_back(pick_script());
            if (hit_ceiling)
                saturated_strings++;
            clear_state();
        end
    endfunction

    // Sample both ports at the rising edge, inputs first so a prediction is queued in time.
    always @(posedge clk or negedge rst_n)
    begin : watch_ports
        script_t want;
        if (!rst_n)
        begin
            clear_state();
            expected_scripts.delete();
            codes_seen  = '0;
            outstanding = 0;
        end
        else
        begin
            if (push && !full)
            begin
                bytes_seen++;
                absorb_byte(text_byte, is_last);
            end
            if (pop && !empty)
            begin
                if (expected_scripts.size() == 0)
                begin
                    flag_mismatch($sformatf("script code %0d popped with no string pending",
                                            script_code));
                end
                else
                begin
                    want = expected_scripts.pop_front();
                    strings_seen++;
                    codes_seen[want] = 1'b1;
                    if (script_code !== want)
                        flag_mismatch($sformatf("script_code %0d, expected %0d (%s)",
                                                script_code, want, want.name()));
                end
            end
            outstanding = expected_scripts.size();
        end
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the script classifier: directed strings first, then random
// strings of mixed scripts, noise bytes and truncated endings.
module testbench;

    localparam int COUNT_W     = 4;
    localparam int BYTE_TARGET = 1700;
    localparam int CALM_TAIL   = 250;

    // Kinds of code point the random strings are built from.
    typedef enum int {
        FL_LATIN, FL_ASCII, FL_CYR, FL_ARA, FL_CJK, FL_DEV, FL_TURK, FL_WIDE, FL_BORDER
    } cp_flavor_t;

    // Code points at and next to every class boundary, next to some marker letters, and the top code point.
    localparam logic [20:0] BORDER_POINTS [40] = '{
        21'h3FF,  21'h400,  21'h4FF,  21'h500,
        21'h40,   21'h41,   21'h5A,   21'h5B,   21'h60,   21'h61,   21'h7A,  21'h7B,
        21'h5FF,  21'h600,  21'h6FF,  21'h700,
        21'h4DFF, 21'h4E00, 21'h9FFF, 21'hA000,
        21'h303F, 21'h3040, 21'h30FF, 21'h3100,
        21'hABFF, 21'hAC00, 21'hD7AF, 21'hD7B0,
        21'h8FF,  21'h900,  21'h97F,  21'h980,
        21'hC3,   21'hC5,   21'hE3,   21'hE5,   21'h146,  21'h149,  21'h17F, 21'h1FFFFF
    };

    localparam logic [20:0] TURK_POINTS [10] = '{
        21'hC4, 21'hE4, 21'hDD, 21'hFD, 21'h147, 21'h148, 21'h15E, 21'h15F, 21'h17D, 21'h17E
    };

    // Directed strings as {is_last, byte}: single letter, extreme bytes with a bad lead,
    // Cyrillic, Turkmen letter, CJK, Devanagari, Arabic, a truncated four-byte lead whose
    // stored followers form an Arabic letter, a lone lead as last byte, a stray follower.
    localparam logic [8:0] DIRECTED [24] = '{
        {1'b1, 8'h41},
        {1'b0, 8'h00}, {1'b1, 8'hFF},
        {1'b0, 8'hD0}, {1'b0, 8'h96}, {1'b0, 8'hD0}, {1'b1, 8'hB6},
        {1'b0, 8'hC3}, {1'b1, 8'hA4},
        {1'b0, 8'hE4}, {1'b0, 8'hB8}, {1'b1, 8'hAD},
        {1'b0, 8'hE0}, {1'b0, 8'hA4}, {1'b1, 8'h95},
        {1'b0, 8'hD8}, {1'b1, 8'hA7},
        {1'b0, 8'hF0}, {1'b0, 8'hD8}, {1'b1, 8'hA7},
        {1'b0, 8'h61}, {1'b1, 8'hE2},
        {1'b0, 8'h80}, {1'b1, 8'h62}
    };

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] text_byte;
    logic       is_last;
    logic       empty;
    logic       pop;
    logic [2:0] script_code;

    int         mismatches;
    int         outstanding;
    int         bytes_seen;
    int         strings_seen;
    int         saturated_strings;
    logic [5:0] codes_seen;

    logic       calm;
    logic       gappy;
    int         bytes_sent;
    logic [7:0] word_bytes [$];

    utf8_script_classifier_core #(
        .COUNT_BITS(COUNT_W)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .text_byte  (text_byte),
        .is_last    (is_last),
        .empty      (empty),
        .pop        (pop),
        .script_code(script_code)
    );

    script_code_checker #(
        .COUNT_BITS(COUNT_W)
    ) u_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .text_byte        (text_byte),
        .is_last          (is_last),
        .empty            (empty),
        .pop              (pop),
        .script_code      (script_code),
        .mismatches       (mismatches),
        .outstanding      (outstanding),
        .bytes_seen       (bytes_seen),
        .strings_seen     (strings_seen),
        .saturated_strings(saturated_strings),
        .codes_seen       (codes_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one item at a falling edge and hold it until a rising edge takes it.
    task automatic put_byte(input logic [7:0] b, input logic last);
        if (!calm && gappy && $urandom_range(0, 4) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        push      <= 1'b1;
        text_byte <= b;
        is_last   <= last;
        forever
        begin
            @(posedge clk);
            if (!full)
                break;
        end
        @(negedge clk);
        bytes_sent++;
    endtask

    // Stop sending until every predicted script code has been popped.
    task automatic hold_until_drained();
        push <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (outstanding == 0)
                break;
        end
    endtask

    task automatic append_cp(input logic [20:0] cp);
        if (cp < 21'h80)
        begin
            word_bytes.push_back(cp[7:0]);
        end
        else if (cp < 21'h800)
        begin
            word_bytes.push_back({3'b110, cp[10:6]});
            word_bytes.push_back({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000)
        begin
            word_bytes.push_back({4'b1110, cp[15:12]});
            word_bytes.push_back({2'b10, cp[11:6]});
            word_bytes.push_back({2'b10, cp[5:0]});
        end
        else
        begin
            word_bytes.push_back({5'b11110, cp[20:18]});
            word_bytes.push_back({2'b10, cp[17:12]});
            word_bytes.push_back({2'b10, cp[11:6]});
            word_bytes.push_back({2'b10, cp[5:0]});
        end
    endtask

    function automatic logic [20:0] draw_cp(input cp_flavor_t flavor);
        case (flavor)
            FL_LATIN:
                return ($urandom_range(0, 1) == 0) ? 21'($urandom_range('h41, 'h5A))
                                                   : 21'($urandom_range('h61, 'h7A));
            FL_ASCII:  return 21'($urandom_range(0, 'h7F));
            FL_CYR:    return 21'($urandom_range('h400, 'h4FF));
            FL_ARA:    return 21'($urandom_range('h600, 'h6FF));
            FL_CJK:
                case ($urandom_range(0, 2))
                    0:       return 21'($urandom_range('h4E00, 'h9FFF));
                    1:       return 21'($urandom_range('h3040, 'h30FF));
                    default: return 21'($urandom_range('hAC00, 'hD7AF));
                endcase
            FL_DEV:    return 21'($urandom_range('h900, 'h97F));
            FL_TURK:   return TURK_POINTS[$urandom_range(0, 9)];
            FL_WIDE:
                return ($urandom_range(0, 1) == 0) ? 21'($urandom_range('h80, 'hFFFF))
                                                   : 21'($urandom_range('h10000, 'h1FFFFF));
            default:   return BORDER_POINTS[$urandom_range(0, 39)];
        endcase
    endfunction

    // One random string: mostly one script, some other code points, noise bytes,
    // rare marker letters, and now and then a sequence cut off by the end of the string.
    task automatic build_word();
        cp_flavor_t main_flavor;
        int         n;
        int         r;
        int         v;
        int         span;
        word_bytes.delete();
        main_flavor = cp_flavor_t'($urandom_range(0, 5));
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 10);
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                word_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else if (r < 70)
            begin
                append_cp(draw_cp(main_flavor));
            end
            else if (r < 71)
            begin
                append_cp(draw_cp(FL_TURK));
            end
            else
            begin
                v = $urandom_range(0, 7);
                if (v >= FL_TURK)
                    v++;
                append_cp(draw_cp(cp_flavor_t'(v)));
            end
        end

        if ($urandom_range(0, 4) == 0)
        begin
            span = $urandom_range(2, 4);
            case (span)
                2:       word_bytes.push_back({3'b110, 5'($urandom_range(0, 31))});
                3:       word_bytes.push_back({4'b1110, 4'($urandom_range(0, 15))});
                default: word_bytes.push_back({5'b11110, 3'($urandom_range(0, 7))});
            endcase
            if (span == 4 && $urandom_range(0, 2) == 0)
            begin
                append_cp(draw_cp(($urandom_range(0, 1) == 0) ? FL_CYR : FL_ARA));
            end
            else
            begin
                repeat ($urandom_range(0, span - 2))
                begin
                    if ($urandom_range(0, 1) == 0)
                        word_bytes.push_back({2'b10, 6'($urandom_range(0, 63))});
                    else
                        word_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end
        end

        if (word_bytes.size() == 0)
            word_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic send_word();
        for (int i = 0; i < word_bytes.size(); i++)
            put_byte(word_bytes[i], i == word_bytes.size() - 1);
    endtask

    // Result side: pop stalls in random bursts, with calm stretches, and none at the end.
    initial
    begin : pop_driver
        logic steady;
        pop    = 1'b0;
        steady = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 199) == 0)
                steady = ~steady;
            if (!calm && !steady && $urandom_range(0, 9) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // Main sequence: reset, directed strings, random strings, drain, verdict.
    initial
    begin : stimulus
        int words;
        rst_n      = 1'b0;
        push       = 1'b0;
        text_byte  = '0;
        is_last    = 1'b0;
        calm       = 1'b0;
        gappy      = 1'b1;
        bytes_sent = 0;
        words      = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < 24; i++)
            put_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
        hold_until_drained();

        while (bytes_sent < BYTE_TARGET)
        begin
            calm = (bytes_sent >= BYTE_TARGET - CALM_TAIL);
            if (words % 25 == 0)
                gappy = ($urandom_range(0, 2) != 0);
            build_word();
            send_word();
            words++;
            if (words == 120)
                hold_until_drained();
        end

        hold_until_drained();
        repeat (20) @(negedge clk);

        $display("Checked %0d strings over %0d bytes with a %0d-bit counter width.",
                 strings_seen, bytes_seen, COUNT_W);
        $display("Script codes seen (one bit per code): %06b; strings with a saturated counter: %0d",
                 codes_seen, saturated_strings);
        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog in case a handshake never completes.
    initial
    begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
sv/usc_pkg.sv
sv/usc_fifo.sv
sv/usc_front.sv
sv/usc_back.sv
sv/utf8_script_classifier_core.sv
bench/script_code_checker.sv
bench/testbench.sv
